/* rtl/core/window_magnitude_variance_defines.svh */
// assertion macros for the window magnitude variance block
// used by the top level only, no other dependencies
`ifndef WINDOW_MAGNITUDE_VARIANCE_DEFINES_SVH
`define WINDOW_MAGNITUDE_VARIANCE_DEFINES_SVH

`ifndef SYNTHESIS
`define WMV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wmv assertion failed");
`define WMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wmv assertion failed");
`else
`define WMV_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WMV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/wmv_pkg.sv */
// shared widths, register indexes and control types for the window magnitude variance block
// no dependencies
package wmv_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int VAR_W      = 33;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int WIN_W      = 9;
   localparam int DIMS_W     = 3;
   localparam int COMP_W     = 2;
   localparam int STEP_W     = 8;
   localparam int SQACC_W    = 33;
   localparam int ROOT_W     = 17;
   localparam int MSUM_W     = 25;
   localparam int MSQ_W      = 41;
   localparam int NUM_W      = 50;
   localparam int DEN_W      = 16;
   localparam int MUL_A_W    = 41;
   localparam int MUL_B_W    = 25;
   localparam int REM_W      = 20;
   localparam int CNT_W      = 6;

   localparam logic [WIN_W-1:0]  MAX_WINDOW = 9'd256;
   localparam logic [DIMS_W-1:0] MAX_DIMS   = 3'd4;

   localparam logic [CNT_W-1:0] ROOT_STEPS = 6'd17;
   localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd50;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS    = 2'd1;

   typedef enum logic {
      RD_ROOT = 1'b0,
      RD_DIV  = 1'b1
   } rd_mode_type;

   typedef struct packed {
      logic        start;
      rd_mode_type mode;
   } rd_ctrl_type;

endpackage

/* rtl/core/wmv_serial_mul.sv */
// shift-add multiplier, one multiplier bit per cycle, stops when no bits remain
// depends on wmv_pkg
module wmv_serial_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wmv_pkg::MUL_A_W-1:0]  a,
   input  logic [wmv_pkg::MUL_B_W-1:0]  b,
   output logic                         busy,
   output logic [wmv_pkg::NUM_W-1:0]    product
);
   import wmv_pkg::*;

   logic [MUL_B_W-1:0] b_ff;
   logic [NUM_W-1:0]   a_ff;
   logic [NUM_W-1:0]   acc_ff;

   assign busy    = (b_ff != '0);
   assign product = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else if (start) begin
         b_ff <= b;
      end else if (busy) begin
         b_ff <= b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= {{(NUM_W-MUL_A_W){1'b0}}, a};
      end else if (busy) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= {a_ff[NUM_W-2:0], 1'b0};
      end
   end

endmodule

/* rtl/core/wmv_root_div.sv */
// restoring square root (two bits a cycle) and restoring divide (one bit a cycle)
// sharing one remainder register and subtractor; depends on wmv_pkg
module wmv_root_div (
   input  logic                        clock,
   input  logic                        reset,
   input  wmv_pkg::rd_ctrl_type        ctrl,
   input  logic [wmv_pkg::NUM_W-1:0]   opnd,
   input  logic [wmv_pkg::DEN_W-1:0]   divisor,
   output logic                        busy,
   output logic [wmv_pkg::ROOT_W-1:0]  root,
   output logic [wmv_pkg::VAR_W-1:0]   quotient
);
   import wmv_pkg::*;

   logic [CNT_W-1:0]  count_ff;
   rd_mode_type       mode_ff;
   logic [DEN_W-1:0]  div_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [NUM_W-1:0]  work_ff;

   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic [REM_W:0]    diff;
   logic              ge;

   assign busy     = (count_ff != '0);
   assign root     = root_ff;
   assign quotient = work_ff[VAR_W-1:0];

   always_comb begin
      if (mode_ff == RD_ROOT) begin
         rem_sh = {rem_ff[REM_W-3:0], work_ff[NUM_W-1:NUM_W-2]};
         trial  = {1'b0, root_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[REM_W-2:0], work_ff[NUM_W-1]};
         trial  = {{(REM_W-DEN_W){1'b0}}, div_ff};
      end
      diff = {1'b0, rem_sh} - {1'b0, trial};
      ge   = ~diff[REM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.start) begin
         count_ff <= (ctrl.mode == RD_ROOT) ? ROOT_STEPS : DIV_STEPS;
      end else if (busy) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         mode_ff <= ctrl.mode;
         div_ff  <= divisor;
         rem_ff  <= '0;
         root_ff <= '0;
         if (ctrl.mode == RD_ROOT) begin
            work_ff <= {1'b0, opnd[SQACC_W-1:0], {(NUM_W-SQACC_W-1){1'b0}}};
         end else begin
            work_ff <= opnd;
         end
      end else if (busy) begin
         rem_ff <= ge ? diff[REM_W-1:0] : rem_sh;
         if (mode_ff == RD_ROOT) begin
            root_ff <= {root_ff[ROOT_W-2:0], ge};
            work_ff <= {work_ff[NUM_W-3:0], 2'b00};
         end else begin
            work_ff <= {work_ff[NUM_W-2:0], ge};
         end
      end
   end

endmodule

/* rtl/core/window_magnitude_variance.sv */
// window magnitude variance top level: sequencer, accumulators, config and result register
// depends on wmv_pkg, wmv_serial_mul, wmv_root_div and window_magnitude_variance_defines.svh
// one word at a time: each component is squared by the shift-add multiplier, one bit a cycle;
// the last component of a time step adds the magnitude root and the magnitude square;
// the last step of a window of two or more steps adds three shift-add multiplies and a divide
// strobe with busy low; results cannot be stalled; sync reset: window 1, dims 1, sums cleared
`include "window_magnitude_variance_defines.svh"

module window_magnitude_variance (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [wmv_pkg::SAMPLE_W-1:0] req_component,
   output logic                              busy,
   output logic                              rsp_valid,
   output logic [wmv_pkg::VAR_W-1:0]         rsp_variance,
   input  logic                              csr_wr_en,
   input  logic [wmv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wmv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wmv_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SQUARE = 8'b0000_0010,
      S_ROOT   = 8'b0000_0100,
      S_MSQ    = 8'b0000_1000,
      S_NMUL   = 8'b0001_0000,
      S_SMUL   = 8'b0010_0000,
      S_DMUL   = 8'b0100_0000,
      S_DIV    = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [WIN_W-1:0]   win_ff, win_in;
   logic [DIMS_W-1:0]  dims_ff, dims_in;
   logic [COMP_W-1:0]  comp_ff, comp_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SQACC_W-1:0] sqacc_ff, sqacc_in;
   logic [MSUM_W-1:0]  msum_ff, msum_in;
   logic [MSQ_W-1:0]   msq_ff, msq_in;
   logic [WIN_W-1:0]   n_ff, n_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VAR_W-1:0]   rsp_var_ff, rsp_var_in;

   logic [WIN_W-1:0]   eff_win;
   logic [DIMS_W-1:0]  eff_dims;
   logic [SAMPLE_W-1:0] mag;
   logic [SQACC_W-1:0] sq_sum;
   logic [DIMS_W-1:0]  comp_next;
   logic [WIN_W-1:0]   step_next;
   logic [MSQ_W-1:0]   msq_sum;
   logic [MSUM_W-1:0]  msum_sum;
   logic [WIN_W-1:0]   n_less;

   logic               mul_start;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic               mul_busy;
   logic [NUM_W-1:0]   mul_product;

   rd_ctrl_type        rd_ctrl;
   logic [NUM_W-1:0]   rd_opnd;
   logic [DEN_W-1:0]   rd_divisor;
   logic               rd_busy;
   logic [ROOT_W-1:0]  rd_root;
   logic [VAR_W-1:0]   rd_quot;

   wmv_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .busy    (mul_busy),
      .product (mul_product)
   );

   wmv_root_div u_root_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rd_ctrl),
      .opnd     (rd_opnd),
      .divisor  (rd_divisor),
      .busy     (rd_busy),
      .root     (rd_root),
      .quotient (rd_quot)
   );

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_variance = rsp_var_ff;

   always_comb begin
      if (win_ff == '0) begin
         eff_win = 9'd1;
      end else if (win_ff > MAX_WINDOW) begin
         eff_win = MAX_WINDOW;
      end else begin
         eff_win = win_ff;
      end
      if (dims_ff == '0) begin
         eff_dims = 3'd1;
      end else if (dims_ff > MAX_DIMS) begin
         eff_dims = MAX_DIMS;
      end else begin
         eff_dims = dims_ff;
      end
   end

   // magnitude of the sample, most negative value gives 2^15
   assign mag       = req_component[SAMPLE_W-1] ? (~req_component + 1'b1) : req_component;
   assign sq_sum    = sqacc_ff + mul_product[SQACC_W-1:0];
   assign comp_next = {1'b0, comp_ff} + 3'd1;
   assign step_next = {1'b0, step_ff} + 9'd1;
   assign msq_sum   = msq_ff + {{(MSQ_W-SQACC_W){1'b0}}, mul_product[SQACC_W-1:0]};
   assign msum_sum  = msum_ff + {{(MSUM_W-ROOT_W){1'b0}}, rd_root};
   assign n_less    = n_ff - 9'd1;

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      dims_in      = dims_ff;
      comp_in      = comp_ff;
      step_in      = step_ff;
      sqacc_in     = sqacc_ff;
      msum_in      = msum_ff;
      msq_in       = msq_ff;
      n_in         = n_ff;
      num_in       = num_ff;
      rsp_valid_in = 1'b0;
      rsp_var_in   = rsp_var_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      rd_ctrl      = '{start: 1'b0, mode: RD_ROOT};
      rd_opnd      = '0;
      rd_divisor   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mul_start = 1'b1;
               mul_a     = {{(MUL_A_W-SAMPLE_W){1'b0}}, mag};
               mul_b     = {{(MUL_B_W-SAMPLE_W){1'b0}}, mag};
               state_in  = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (!mul_busy) begin
               if (comp_next < eff_dims) begin
                  sqacc_in = sq_sum;
                  comp_in  = comp_next[COMP_W-1:0];
                  state_in = S_IDLE;
               end else begin
                  sqacc_in = '0;
                  comp_in  = '0;
                  rd_ctrl  = '{start: 1'b1, mode: RD_ROOT};
                  rd_opnd  = {{(NUM_W-SQACC_W){1'b0}}, sq_sum};
                  state_in = S_ROOT;
               end
            end
         end
         S_ROOT: begin
            if (!rd_busy) begin
               msum_in   = msum_sum;
               mul_start = 1'b1;
               mul_a     = {{(MUL_A_W-ROOT_W){1'b0}}, rd_root};
               mul_b     = {{(MUL_B_W-ROOT_W){1'b0}}, rd_root};
               state_in  = S_MSQ;
            end
         end
         S_MSQ: begin
            if (!mul_busy) begin
               if (step_next < eff_win) begin
                  msq_in   = msq_sum;
                  step_in  = step_next[STEP_W-1:0];
                  state_in = S_IDLE;
               end else if (step_next < 9'd2) begin
                  // single step window
                  rsp_valid_in = 1'b1;
                  rsp_var_in   = '0;
                  comp_in      = '0;
                  step_in      = '0;
                  sqacc_in     = '0;
                  msum_in      = '0;
                  msq_in       = '0;
                  state_in     = S_IDLE;
               end else begin
                  msq_in    = msq_sum;
                  n_in      = step_next;
                  mul_start = 1'b1;
                  mul_a     = msq_sum;
                  mul_b     = {{(MUL_B_W-WIN_W){1'b0}}, step_next};
                  state_in  = S_NMUL;
               end
            end
         end
         S_NMUL: begin
            if (!mul_busy) begin
               num_in    = mul_product;
               mul_start = 1'b1;
               mul_a     = {{(MUL_A_W-MSUM_W){1'b0}}, msum_ff};
               mul_b     = msum_ff;
               state_in  = S_SMUL;
            end
         end
         S_SMUL: begin
            if (!mul_busy) begin
               num_in    = num_ff - mul_product;
               mul_start = 1'b1;
               mul_a     = {{(MUL_A_W-WIN_W){1'b0}}, n_ff};
               mul_b     = {{(MUL_B_W-WIN_W){1'b0}}, n_less};
               state_in  = S_DMUL;
            end
         end
         S_DMUL: begin
            if (!mul_busy) begin
               rd_ctrl    = '{start: 1'b1, mode: RD_DIV};
               rd_opnd    = num_ff;
               rd_divisor = mul_product[DEN_W-1:0];
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            if (!rd_busy) begin
               rsp_valid_in = 1'b1;
               rsp_var_in   = rd_quot;
               comp_in      = '0;
               step_in      = '0;
               sqacc_in     = '0;
               msum_in      = '0;
               msq_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // writes to the window size or dims register restart the window
      if (csr_wr_en && (csr_index == CSR_WINDOW_SIZE || csr_index == CSR_NUM_DIMS)) begin
         if (csr_index == CSR_WINDOW_SIZE) begin
            win_in = csr_wdata[WIN_W-1:0];
         end else begin
            dims_in = csr_wdata[DIMS_W-1:0];
         end
         comp_in  = '0;
         step_in  = '0;
         sqacc_in = '0;
         msum_in  = '0;
         msq_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_ff       <= 9'd1;
         dims_ff      <= 3'd1;
         comp_ff      <= '0;
         step_ff      <= '0;
         sqacc_ff     <= '0;
         msum_ff      <= '0;
         msq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         dims_ff      <= dims_in;
         comp_ff      <= comp_in;
         step_ff      <= step_in;
         sqacc_ff     <= sqacc_in;
         msum_ff      <= msum_in;
         msq_ff       <= msq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      num_ff     <= num_in;
      rsp_var_ff <= rsp_var_in;
   end

   `WMV_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `WMV_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `WMV_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `WMV_ASSERT_IMPL(a_units_exclusive, clock, reset, mul_busy, !rd_busy)

endmodule

/* tb/sv/wmv_variance_checker.sv */
// checker for the window magnitude variance block: follows the register writes and accepted
// words, predicts each window's variance and compares it with the result port
// depends on wmv_pkg only
module wmv_variance_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [wmv_pkg::SAMPLE_W-1:0] req_component,
   input  logic                                busy,
   input  logic                                rsp_valid,
   input  logic [wmv_pkg::VAR_W-1:0]           rsp_variance,
   input  logic                                csr_wr_en,
   input  logic [wmv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wmv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  windows_in_flight,
   output int                                  mismatches
);
   import wmv_pkg::*;

   logic [WIN_W-1:0]  win_size;
   logic [DIMS_W-1:0] dims;
   int unsigned       comps_seen;
   int unsigned       steps_seen;
   logic [63:0]       step_squares;
   logic [63:0]       mag_total;
   logic [63:0]       mag_square_total;
   logic [VAR_W-1:0]  variances[$];
   int                errors = 0;

   assign mismatches = errors;

   function automatic logic [63:0] floor_root(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] trial;
      root = 64'd0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   task automatic clear_window();
      comps_seen       = 0;
      steps_seen       = 0;
      step_squares     = 64'd0;
      mag_total        = 64'd0;
      mag_square_total = 64'd0;
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t: window variance mismatch: %s", $time, what);
      errors++;
   endtask

   task automatic enqueue_variance(input logic [VAR_W-1:0] value);
      variances.insert(variances.size(), value);
   endtask

   task automatic absorb_component(input logic signed [SAMPLE_W-1:0] value);
      logic [63:0] size_abs;
      logic [63:0] root;
      logic [63:0] n;
      int unsigned eff_win;
      int unsigned eff_dims;
      eff_win  = (win_size == 0) ? 1 : (win_size > MAX_WINDOW) ? MAX_WINDOW : win_size;
      eff_dims = (dims == 0) ? 1 : (dims > MAX_DIMS) ? MAX_DIMS : dims;
      size_abs = (value < 0) ? 64'(-longint'(value)) : 64'(longint'(value));
      step_squares += size_abs * size_abs;
      comps_seen++;
      if (comps_seen < eff_dims) begin
         return;
      end
      root = floor_root(step_squares);
      step_squares = 64'd0;
      comps_seen = 0;
      mag_total += root;
      mag_square_total += root * root;
      steps_seen++;
      if (steps_seen < eff_win) begin
         return;
      end
      n = 64'(steps_seen);
      if (n < 2) begin
         enqueue_variance('0);
      end else begin
         enqueue_variance(VAR_W'((n * mag_square_total - mag_total * mag_total)
                                 / (n * (n - 64'd1))));
      end
      clear_window();
   endtask

   task automatic check_variance(input logic [VAR_W-1:0] got);
      logic [VAR_W-1:0] want;
      if (variances.size() == 0) begin
         report_mismatch($sformatf("variance %0d with no window pending", got));
      end else begin
         want = variances.pop_front();
         if (got !== want) begin
            report_mismatch($sformatf("variance %0d, predicted %0d", got, want));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         win_size = 9'd1;
         dims     = 3'd1;
         clear_window();
         variances.delete();
      end else begin
         if (rsp_valid) begin
            check_variance(rsp_variance);
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_WINDOW_SIZE) begin
               win_size = csr_wdata[WIN_W-1:0];
               clear_window();
            end else if (csr_index == CSR_NUM_DIMS) begin
               dims = csr_wdata[DIMS_W-1:0];
               clear_window();
            end
         end
         if (start && !busy) begin
            absorb_component(req_component);
         end
      end
      windows_in_flight <= variances.size();
   end

endmodule

/* tb/sv/tb_window_magnitude_variance.sv */
// testbench top for the window magnitude variance block: clock, reset, register writes,
// directed and random words with sender gaps, and the verdict
// depends on wmv_pkg, window_magnitude_variance and wmv_variance_checker
module tb_window_magnitude_variance;
   import wmv_pkg::*;

   localparam int WORD_TARGET   = 1950;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 2000000;

   localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_EXTREME,
      SPREAD_SMALL,
      SPREAD_HIGH
   } spread_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic signed [SAMPLE_W-1:0] req_component;
   logic                       busy;
   logic                       rsp_valid;
   logic [VAR_W-1:0]           rsp_variance;
   logic                       csr_wr_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;
   int                         windows_in_flight;
   int                         mismatches;
   int                         idle_pct;
   int                         words_sent;
   int                         cycle_count = 0;
   logic [WIN_W-1:0]           cur_win;
   logic [DIMS_W-1:0]          cur_dims;

   window_magnitude_variance i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_component (req_component),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_variance  (rsp_variance),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   wmv_variance_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_component     (req_component),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_variance      (rsp_variance),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .windows_in_flight (windows_in_flight),
      .mismatches        (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("window_magnitude_variance test failed");
         $finish;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_component(input spread_type spread);
      logic signed [SAMPLE_W-1:0] v;
      case (spread)
         SPREAD_FULL: return SAMPLE_W'($urandom);
         SPREAD_EXTREME: begin
            case ($urandom_range(4))
               0: return FULL_POS;
               1: return FULL_NEG;
               2: return 16'sd0;
               3: return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         SPREAD_SMALL: return SAMPLE_W'(int'($urandom_range(255)) - 128);
         default: begin
            v = SAMPLE_W'(30000 + $urandom_range(2767));
            return $urandom_range(1) ? -v : v;
         end
      endcase
   endfunction

   // start stays high from one word to the next unless a gap is drawn
   task automatic send_word(input logic signed [SAMPLE_W-1:0] value);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_component <= SAMPLE_W'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) begin
            req_component <= SAMPLE_W'($urandom);
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_component <= value;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (windows_in_flight != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [WIN_W-1:0] win, input logic [DIMS_W-1:0] dims);
      settle();
      if (win != cur_win || $urandom_range(1)) begin
         write_reg(CSR_WINDOW_SIZE, CSR_DATA_W'(win));
      end
      if (dims != cur_dims || $urandom_range(1)) begin
         write_reg(CSR_NUM_DIMS, {(CSR_DATA_W-DIMS_W)'($urandom), dims});
      end
      csr_wr_en <= 1'b0;
      cur_win  = win;
      cur_dims = dims;
   endtask

   // write to an index that maps to no register, state must survive it
   task automatic poke_spare();
      logic [CSR_IDX_W-1:0] index;
      settle();
      do index = CSR_IDX_W'($urandom);
      while (index == CSR_WINDOW_SIZE || index == CSR_NUM_DIMS);
      write_reg(index, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int         seg;
      int         windows;
      int         span;
      int         eff_win;
      int         eff_dims;
      spread_type spread;
      reset         = 1'b1;
      start         = 1'b0;
      req_component = '0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      idle_pct      = 0;
      words_sent    = 0;
      cur_win       = 9'd1;
      cur_dims      = 3'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-step windows at reset values
      send_word(16'sd0);
      send_word(FULL_POS);
      send_word(FULL_NEG);
      send_word(-16'sd1);
      send_word(16'sd1);
      // two-step windows at the sample extremes
      configure(9'd2, 3'd1);
      send_word(FULL_POS);
      send_word(FULL_NEG);
      send_word(16'sd0);
      send_word(FULL_NEG);
      // largest possible spread of magnitudes
      configure(9'd2, 3'd4);
      repeat (4) send_word(FULL_NEG);
      repeat (4) send_word(16'sd0);
      // zero window and zero dims act as one
      configure(9'd0, 3'd0);
      send_word(FULL_NEG);
      // spare index write inside a window
      configure(9'd3, 3'd1);
      send_word(16'sd5);
      poke_spare();
      send_word(16'sd9);
      send_word(-16'sd400);
      // partial window dropped by a register write
      send_word(16'sd7);
      send_word(-16'sd7);
      configure(9'd3, 3'd2);

      seg = 0;
      while (words_sent < WORD_TARGET) begin
         case (seg % 3)
            0: idle_pct = 0;
            1: idle_pct = 65;
            default: idle_pct = 27;
         endcase
         if (seg == 5) begin
            configure(MAX_WINDOW, DIMS_W'($urandom_range(1)));
            windows = 1;
         end else if (seg == 14) begin
            configure(9'h1ff, 3'd1);
            windows = 1;
         end else begin
            configure(($urandom_range(9) == 0) ? WIN_W'($urandom_range(1))
                                              : WIN_W'($urandom_range(2, 8)),
                      DIMS_W'($urandom));
            windows = $urandom_range(1, 5);
         end
         eff_win  = (cur_win == 0) ? 1 : (cur_win > MAX_WINDOW) ? MAX_WINDOW : cur_win;
         eff_dims = (cur_dims == 0) ? 1 : (cur_dims > MAX_DIMS) ? MAX_DIMS : cur_dims;
         span = eff_win * eff_dims;
         repeat (windows) begin
            spread = spread_type'($urandom_range(3));
            repeat (span) send_word(pick_component(spread));
         end
         if (span > 1 && $urandom_range(2) == 0) begin
            spread = spread_type'($urandom_range(3));
            windows = $urandom_range(1, span - 1);
            repeat (windows) send_word(pick_component(spread));
            if ($urandom_range(1)) begin
               poke_spare();
               repeat (span - windows) send_word(pick_component(spread));
            end
         end
         seg++;
      end

      settle();
      if (mismatches == 0) begin
         $display("window_magnitude_variance test passed");
      end else begin
         $display("window_magnitude_variance test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/wmv_pkg.sv
rtl/core/wmv_serial_mul.sv
rtl/core/wmv_root_div.sv
rtl/core/window_magnitude_variance.sv
tb/sv/wmv_variance_checker.sv
tb/sv/tb_window_magnitude_variance.sv
